>>> sv/fac_plru_pkg.sv
// ----------------------------------------------------------------------------
// fac_plru_pkg
// Shared constants and controller/datapath handshake types for the
// fully associative tree-PLRU tag store.
// ----------------------------------------------------------------------------
package fac_plru_pkg;

    localparam int ADDR_W         = 37;
    localparam int HIT_CNT_W      = 32;
    localparam int LINES_DEF      = 512;
    localparam int LINE_BYTES_DEF = 32;
    localparam int TAG_WIDTH_DEF  = 32;

    // tags compared per RAM row
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    typedef struct packed {
        logic clr;   // clearing pass step
        logic load;  // capture a new word
        logic scan;  // tag row read / compare
        logic walk;  // victim walk step
        logic ups;   // fill victim, count hit, seed path update
        logic upd;   // one tree node update
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic cmp_hit;
        logic cmp_end;
        logic leaf;
        logic upd_done;
    } t_dp_sts;

endpackage

>>> sv/fac_plru_ctrl.sv
// ----------------------------------------------------------------------------
// fac_plru_ctrl
// Sequencer: clearing pass, tag scan, victim walk, fill and path update.
// ----------------------------------------------------------------------------
module fac_plru_ctrl import fac_plru_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_UPS   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.cmp_hit)      n_state = S_UPS;
                else if (i_sts.cmp_end) n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.leaf) n_state = S_UPS;
            end
            S_UPS: begin
                o_cmd.ups = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_sts.upd_done) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> sv/fac_plru_dp.sv
// ----------------------------------------------------------------------------
// fac_plru_dp
// Tag RAM (LANES tags per row, valid bit stored with each tag), tree-bit RAM,
// row compare, tree walk / update and the hit counter.
// ----------------------------------------------------------------------------
module fac_plru_dp import fac_plru_pkg::*; #(
    parameter int LINES      = LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int TAG_WIDTH  = TAG_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  logic [ADDR_W-1:0]          i_address,
    output t_dp_sts                    o_sts,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [$clog2(LINES)-1:0]   o_line_used,
    output logic [HIT_CNT_W-1:0]       o_hit_total
);

    localparam int LINE_W = $clog2(LINES);
    localparam int OFF_W  = $clog2(LINE_BYTES + 1) - 1;
    localparam int ROWS   = (LINES + LANES - 1) / LANES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PA_W   = LINE_W;
    localparam int NODE_W = LINE_W + 1;
    localparam int ENT_W  = TAG_WIDTH + 1;
    localparam int LX_W   = ROW_W + LANE_W;

    // tag extract
    logic [ADDR_W+TAG_WIDTH-1:0] addr_ext;
    logic [TAG_WIDTH-1:0]        tag_in;
    assign addr_ext = {{TAG_WIDTH{1'b0}}, i_address} >> OFF_W;
    assign tag_in   = addr_ext[TAG_WIDTH-1:0];

    logic [TAG_WIDTH-1:0] r_tag;
    logic [ROW_W-1:0]     r_row;
    logic                 r_row_ok;
    logic                 r_cmp_vld;
    logic [ROW_W-1:0]     r_cmp_row;
    logic [LINE_W-1:0]    r_line;
    logic                 r_hit;
    logic [NODE_W-1:0]    r_node;
    logic                 r_pq;
    logic [PA_W-1:0]      r_clr;
    logic [HIT_CNT_W-1:0] r_hit_cnt;
    logic                 r_done;

    // ---------------- tag RAM, one array per lane ----------------
    logic [ENT_W-1:0]  lane_q [LANES];
    logic [LANES-1:0]  lane_we;
    logic [ROW_W-1:0]  wr_row;
    logic [ENT_W-1:0]  wr_data;
    logic [LX_W-1:0]   fill_x;
    logic              clr_in_rows;
    logic              rd_en;

    assign fill_x      = LX_W'(r_line);
    assign clr_in_rows = (r_clr < PA_W'(ROWS));
    assign wr_row      = i_cmd.clr ? r_clr[ROW_W-1:0] : fill_x[LX_W-1:LANE_W];
    assign wr_data     = i_cmd.clr ? '0 : {1'b1, r_tag};
    assign rd_en       = i_cmd.scan && r_row_ok;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [ENT_W-1:0] mem [ROWS];
        logic [ENT_W-1:0] r_q;

        assign lane_we[l] = (i_cmd.clr && clr_in_rows) ||
                            (i_cmd.ups && !r_hit && (fill_x[LANE_W-1:0] == LANE_W'(l)));

        always_ff @(posedge i_clk) begin
            if (lane_we[l]) mem[wr_row] <= wr_data;
        end

        always_ff @(posedge i_clk) begin
            if (rd_en) r_q <= mem[r_row];
        end

        assign lane_q[l] = r_q;
    end

    // ---------------- row compare ----------------
    logic [LANES-1:0]  match;
    logic [LANE_W-1:0] hit_lane;
    logic [LX_W-1:0]   hit_x;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            match[l] = lane_q[l][ENT_W-1] && (lane_q[l][TAG_WIDTH-1:0] == r_tag);
        end
        hit_lane = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (match[l]) hit_lane = LANE_W'(l);
        end
    end

    assign hit_x = {r_cmp_row, hit_lane};

    // ---------------- tree-bit RAM ----------------
    logic              pl_mem [LINES-1];
    logic              pl_we;
    logic [PA_W-1:0]   pl_wa;
    logic              pl_wd;
    logic              pl_re;
    logic [PA_W-1:0]   pl_ra;
    logic [NODE_W-1:0] nxt_node;
    logic [NODE_W-1:0] par_node;
    logic              leaf;
    logic              upd_done;

    assign nxt_node = {r_node[NODE_W-2:0], 1'b0} + NODE_W'(1) + NODE_W'(r_pq);
    assign par_node = (r_node - NODE_W'(1)) >> 1;
    assign leaf     = (nxt_node >= NODE_W'(LINES - 1));
    assign upd_done = (par_node == '0);

    assign o_sts.clr_done = (r_clr == PA_W'(LINES - 2));
    assign o_sts.cmp_hit  = r_cmp_vld && (|match);
    assign o_sts.cmp_end  = r_cmp_vld && !(|match) && (r_cmp_row == ROW_W'(ROWS - 1));
    assign o_sts.leaf     = leaf;
    assign o_sts.upd_done = upd_done;

    // root read issued as the scan ends with a miss
    assign pl_re = (i_cmd.scan && o_sts.cmp_end) || (i_cmd.walk && !leaf);
    assign pl_ra = i_cmd.walk ? nxt_node[PA_W-1:0] : '0;

    // point the parent away from the child we came from
    assign pl_we = i_cmd.clr || i_cmd.upd;
    assign pl_wa = i_cmd.clr ? r_clr : par_node[PA_W-1:0];
    assign pl_wd = i_cmd.clr ? 1'b0 : r_node[0];

    always_ff @(posedge i_clk) begin
        if (pl_we) pl_mem[pl_wa] <= pl_wd;
    end

    always_ff @(posedge i_clk) begin
        if (pl_re) r_pq <= pl_mem[pl_ra];
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_tag <= tag_in;
        if (i_cmd.scan) r_cmp_row <= r_row;
        if (i_cmd.scan && o_sts.cmp_hit) begin
            r_line <= hit_x[LINE_W-1:0];
            r_hit  <= 1'b1;
        end
        if (i_cmd.scan && o_sts.cmp_end) begin
            r_hit  <= 1'b0;
            r_node <= '0;
        end
        if (i_cmd.walk) begin
            r_node <= nxt_node;
            if (leaf) r_line <= LINE_W'(nxt_node - NODE_W'(LINES - 1));
        end
        if (i_cmd.ups) r_node <= NODE_W'(r_line) + NODE_W'(LINES - 1);
        if (i_cmd.upd) r_node <= par_node;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_row_ok  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_clr     <= '0;
            r_hit_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + PA_W'(1);
            if (i_cmd.load) begin
                r_row     <= '0;
                r_row_ok  <= 1'b1;
                r_cmp_vld <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_cmp_vld <= r_row_ok;
                if (r_row_ok) begin
                    r_row    <= r_row + ROW_W'(1);
                    r_row_ok <= (r_row != ROW_W'(ROWS - 1));
                end
            end
            if (i_cmd.ups && r_hit) r_hit_cnt <= r_hit_cnt + HIT_CNT_W'(1);
            r_done <= i_cmd.upd && upd_done;
        end
    end

    assign o_done      = r_done;
    assign o_hit       = r_hit;
    assign o_line_used = r_line;
    assign o_hit_total = r_hit_cnt;

endmodule

>>> sv/fully_assoc_cache_tree_plru_unit.sv
// Flow: a load, then a scan that ends at a hit in tag row r, where the tag RAM is read
// one row of 8 tags per cycle, then D tree-node updates, D being the tree depth (9 by default);
// a miss scans all ROWS (64) rows and walks D tree levels from the tree-bit RAM before the updates.
// The result strobe follows in the cycle after the last tree write; start is taken again that cycle.
// The next access is taken only once the previous one has finished; the receiver cannot stall.
// Reset: a clearing pass zeroes tags, valid bits and tree bits; busy high.
// ----------------------------------------------------------------------------
// fully_assoc_cache_tree_plru_unit
// Tag store of a fully associative cache with tree pseudo-LRU replacement.
// ----------------------------------------------------------------------------
module fully_assoc_cache_tree_plru_unit import fac_plru_pkg::*; #(
    parameter int LINES      = LINES_DEF,
    parameter int LINE_BYTES = LINE_BYTES_DEF,
    parameter int TAG_WIDTH  = TAG_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [ADDR_W-1:0]          i_address,
    output logic                       o_done,
    output logic                       o_hit,
    output logic [$clog2(LINES)-1:0]   o_line_used,
    output logic [HIT_CNT_W-1:0]       o_hit_total
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fac_plru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    fac_plru_dp #(
        .LINES      (LINES),
        .LINE_BYTES (LINE_BYTES),
        .TAG_WIDTH  (TAG_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_address   (i_address),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_hit       (o_hit),
        .o_line_used (o_line_used),
        .o_hit_total (o_hit_total)
    );

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an access in flight");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_line_used <= ($clog2(LINES))'(LINES - 1)))
        else $error("line out of range");

    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> $stable(o_hit_total))
        else $error("hit counter moved on a miss");

endmodule
